@@ rtl/raib_pkg.sv @@
// shared types and constants for the adaptive iteration bound block
`timescale 1ns / 1ps

package raib_pkg;

   typedef enum logic [2:0] {
      CMD_UPDATE = 3'd0,
      CMD_CHECK  = 3'd1,
      CMD_TICK   = 3'd2,
      CMD_RESET  = 3'd3,
      CMD_START  = 3'd4
   } cmd_type;

   typedef enum logic [2:0] {
      REG_LOG_CONF   = 3'd0,
      REG_POINTS     = 3'd1,
      REG_SAMPLE     = 3'd2,
      REG_ITER_LIMIT = 3'd3,
      REG_TIME_EN    = 3'd4,
      REG_TIME_LIMIT = 3'd5
   } reg_index_type;

   localparam logic [31:0] LN2_Q32 = 32'hB17217F8;

   localparam logic [31:0] RST_LOG_CONF   = 32'hFB652E91; // -77255023
   localparam logic [19:0] RST_POINTS     = 20'd1000;
   localparam logic [4:0]  RST_SAMPLE     = 5'd4;
   localparam logic [23:0] RST_ITER_LIMIT = 24'd10000;
   localparam logic [30:0] RST_TIME_LIMIT = 31'h7FFFFFFF;

   // operations of the shared unit
   typedef enum logic [1:0] {
      OP_DIV  = 2'd0,
      OP_MUL  = 2'd1,
      OP_SQR  = 2'd2
   } op_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } unit_ctl_type;

endpackage

@@ rtl/ransac_adaptive_iteration_bound.sv @@
// top level: adaptive ransac iteration bound with time limit
`timescale 1ns / 1ps
//  channel | ports                                   | dir
//  req     | req_valid req_stall req_command ...     | in
//  rsp     | rsp_valid rsp_stall rsp_stop_now ...    | out
//  csr     | csr_write csr_index csr_data            | in
// check, tick, reset and start items pass through the output state to a registered response
// update with the log path runs these steps in order, all in one shared unit:
// a divide for the ratio, n multiplies for the power loop (n = 1 to 16), 24 squarings,
// the scaling multiply and the second divide
// a zero ratio ends after the power loop, a zero exponent after the first divide,
// a full ratio and a zero point count without using the unit
// synchronous reset restores the registers and the bound; a stalled response
// holds and blocks new requests

module ransac_adaptive_iteration_bound #(
   parameter int MAX_SAMPLE = 16,
   parameter int TIME_BITS  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [19:0] req_inlier_count,
   input  logic [23:0] req_iteration_number,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_stop_now,
   output logic [23:0] rsp_bound_now,
   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int SW = $clog2(MAX_SAMPLE + 1);

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_DIV1  = 10'b0000000010,
      S_POW   = 10'b0000000100,
      S_POWW  = 10'b0000001000,
      S_SQR   = 10'b0000010000,
      S_SQRW  = 10'b0000100000,
      S_SCL   = 10'b0001000000,
      S_SCLW  = 10'b0010000000,
      S_DIV2  = 10'b0100000000,
      S_OUT   = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;

   logic [31:0] lc_ff;
   logic [19:0] pc_ff;
   logic [4:0]  ns_ff;
   logic [23:0] lim_ff;
   logic        ten_ff;
   logic [30:0] tlim_ff;

   logic [23:0] bound_ff, bound_in;
   logic [TIME_BITS-1:0] el_ff, el_in;
   logic        stop_ff, stop_in;
   logic [32:0] w_ff, w_in;     // Q0.32 with 1.0 at bit 32
   logic [32:0] p_ff, p_in;
   logic [SW-1:0] pcnt_ff, pcnt_in;
   logic [32:0] x_ff, x_in;     // Q1.31 mantissa, reduced below 2^32
   logic [4:0]  icnt_ff, icnt_in;
   logic [23:0] frac_ff, frac_in;
   logic [5:0]  e_ff, e_in;
   logic [31:0] mag_ff, mag_in;
   logic        rv_ff, rv_in;

   raib_pkg::unit_ctl_type ctl;
   logic [63:0] ua;
   logic [31:0] ub;
   logic        udone;
   logic [63:0] ures;

   raib_unit u_unit (
      .clock (clock), .reset (reset), .ctl (ctl), .a (ua), .b (ub),
      .done (udone), .result (ures)
   );

   logic [SW-1:0] nsat;
   logic [32:0]   q;
   logic [5:0]    lead;
   logic [31:0]   num;
   logic [63:0]   sq;
   logic [63:0]   scl;

   always_comb begin
      if (int'(ns_ff) > MAX_SAMPLE) nsat = SW'(MAX_SAMPLE);
      else nsat = SW'(ns_ff);
      q    = 33'h100000000 - p_ff;
      lead = '0;
      for (int i = 0; i < 32; i++) if (q[i]) lead = 6'(i);
      num  = lc_ff[31] ? (32'd0 - lc_ff) : 32'd0;
      sq   = ures;
      scl  = ures + 64'h80000000;
   end

   always_comb begin
      state_in = state_ff;
      bound_in = bound_ff;
      el_in    = el_ff;
      stop_in  = stop_ff;
      w_in     = w_ff;
      p_in     = p_ff;
      pcnt_in  = pcnt_ff;
      x_in     = x_ff;
      icnt_in  = icnt_ff;
      frac_in  = frac_ff;
      e_in     = e_ff;
      mag_in   = mag_ff;
      rv_in    = rv_ff;
      ctl      = '{start: 1'b0, op: raib_pkg::OP_MUL};
      ua       = '0;
      ub       = '0;
      if (rv_ff && !rsp_stall) rv_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               stop_in  = 1'b0;
               state_in = S_OUT;
               case (req_command)
                  raib_pkg::CMD_UPDATE: begin
                     if (pc_ff != 20'd0) begin
                        if ({4'd0, req_inlier_count} >= {4'd0, pc_ff}) begin
                           w_in     = 33'h100000000;
                           p_in     = 33'h100000000;
                           pcnt_in  = nsat;
                           state_in = S_POW;
                        end else begin
                           ctl      = '{start: 1'b1, op: raib_pkg::OP_DIV};
                           ua       = {12'd0, req_inlier_count, 32'd0};
                           ub       = {12'd0, pc_ff};
                           state_in = S_DIV1;
                        end
                     end
                  end
                  raib_pkg::CMD_CHECK: begin
                     if (req_iteration_number >= bound_ff) stop_in = 1'b1;
                     else if (ten_ff && 64'(el_ff) > 64'(tlim_ff)) stop_in = 1'b1;
                  end
                  raib_pkg::CMD_TICK: begin
                     if (el_ff != {TIME_BITS{1'b1}}) el_in = el_ff + 1'b1;
                  end
                  raib_pkg::CMD_RESET: bound_in = lim_ff;
                  raib_pkg::CMD_START: el_in = '0;
                  default: ;
               endcase
            end
         end
         S_DIV1: begin
            if (udone) begin
               w_in     = {1'b0, ures[31:0]};
               p_in     = 33'h100000000;
               pcnt_in  = nsat;
               state_in = S_POW;
            end
         end
         S_POW: begin
            if (pcnt_ff == '0 || w_ff[32]) begin
               if (q[32]) state_in = S_OUT;           // power zero (zero ratio or underflow), unchanged
               else if (q == 33'd0) begin              // full ratio or zero exponent
                  if (24'd0 < lim_ff) bound_in = 24'd0;
                  state_in = S_OUT;
               end else begin
                  e_in     = lead;
                  x_in     = {1'b0, q[31:0] << (5'd31 - lead[4:0])};
                  icnt_in  = 5'd0;
                  frac_in  = '0;
                  state_in = S_SQR;
               end
            end else begin
               ctl      = '{start: 1'b1, op: raib_pkg::OP_MUL};
               ua       = {32'd0, p_ff[31:0]};
               ub       = w_ff[31:0];
               state_in = S_POWW;
            end
         end
         S_POWW: begin
            if (udone) begin
               // p is below 1.0 here but for the first pass, where p == 1.0
               p_in     = (p_ff[32]) ? {1'b0, w_ff[31:0]} : {1'b0, ures[63:32]};
               pcnt_in  = pcnt_ff - 1'b1;
               state_in = S_POW;
            end
         end
         S_SQR: begin
            if (icnt_ff == 5'd24) begin
               state_in = S_SCL;
            end else begin
               ctl      = '{start: 1'b1, op: raib_pkg::OP_SQR};
               ua       = {32'd0, x_ff[31:0]};
               ub       = x_ff[31:0];
               state_in = S_SQRW;
            end
         end
         S_SQRW: begin
            if (udone) begin
               if (sq[63]) begin
                  frac_in = {frac_ff[22:0], 1'b1};
                  x_in    = {1'b0, sq[63:32]};
               end else begin
                  frac_in = {frac_ff[22:0], 1'b0};
                  x_in    = {1'b0, sq[62:31]};
               end
               icnt_in  = icnt_ff + 5'd1;
               state_in = S_SQR;
            end
         end
         S_SCL: begin
            ctl      = '{start: 1'b1, op: raib_pkg::OP_MUL};
            ua       = {32'd0, ({2'b00, 6'd32 - e_ff, 24'd0} - {8'd0, frac_ff})};
            ub       = raib_pkg::LN2_Q32;
            state_in = S_SCLW;
         end
         S_SCLW: begin
            if (udone) begin
               mag_in   = scl[63:32];
               ctl      = '{start: 1'b1, op: raib_pkg::OP_DIV};
               ua       = {32'd0, num};
               ub       = scl[63:32];
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            if (udone) begin
               if (ures < {40'd0, lim_ff}) bound_in = ures[23:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rv_ff || !rsp_stall) begin
               rv_in    = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         lc_ff    <= raib_pkg::RST_LOG_CONF;
         pc_ff    <= raib_pkg::RST_POINTS;
         ns_ff    <= raib_pkg::RST_SAMPLE;
         lim_ff   <= raib_pkg::RST_ITER_LIMIT;
         ten_ff   <= 1'b0;
         tlim_ff  <= raib_pkg::RST_TIME_LIMIT;
         bound_ff <= raib_pkg::RST_ITER_LIMIT;
         el_ff    <= '0;
         rv_ff    <= 1'b0;
         stop_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         bound_ff <= bound_in;
         el_ff    <= el_in;
         rv_ff    <= rv_in;
         stop_ff  <= stop_in;
         if (csr_write) begin
            unique case (csr_index)
               raib_pkg::REG_LOG_CONF:   lc_ff   <= csr_data;
               raib_pkg::REG_POINTS:     pc_ff   <= csr_data[19:0];
               raib_pkg::REG_SAMPLE:     ns_ff   <= csr_data[4:0];
               raib_pkg::REG_ITER_LIMIT: lim_ff  <= csr_data[23:0];
               raib_pkg::REG_TIME_EN:    ten_ff  <= csr_data[0];
               raib_pkg::REG_TIME_LIMIT: tlim_ff <= csr_data[30:0];
               default: ;
            endcase
         end
      end
      w_ff    <= w_in;
      p_ff    <= p_in;
      pcnt_ff <= pcnt_in;
      x_ff    <= x_in;
      icnt_ff <= icnt_in;
      frac_ff <= frac_in;
      e_ff    <= e_in;
      mag_ff  <= mag_in;
   end

   assign req_stall     = (state_ff != S_IDLE) || rv_ff;
   assign rsp_valid     = rv_ff;
   assign rsp_stop_now  = stop_ff;
   assign rsp_bound_now = bound_ff;

   a_idle_when_valid: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> req_stall) else $error("request taken with response pending");
   a_bound_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV2 && udone) |=> bound_ff <= $past(lim_ff) || $stable(bound_ff))
      else $error("bound above limit");
   a_mag_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV2) |-> mag_ff != 32'd0) else $error("zero log magnitude");

endmodule

@@ rtl/raib_unit.sv @@
// shared multiply and restoring divide unit
`timescale 1ns / 1ps

module raib_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  raib_pkg::unit_ctl_type ctl,
   input  logic [63:0]           a,
   input  logic [31:0]           b,
   output logic                  done,
   output logic [63:0]           result
);

   // multiply: a[31:0]*b in 64 bits, combinational then registered
   // divide: a / b, 64-bit dividend, 64 steps one bit each
   logic        busy_ff, busy_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] quo_ff, quo_in;
   logic [32:0] rem_ff, rem_in;
   logic [31:0] dsr_ff, dsr_in;
   logic        done_ff, done_in;
   logic [63:0] res_ff, res_in;
   logic [32:0] trial;
   logic [33:0] diff;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      done_in = 1'b0;
      res_in  = res_ff;
      trial   = {rem_ff[31:0], quo_ff[63]};
      diff    = {1'b0, trial} - {2'b00, dsr_ff};
      if (ctl.start) begin
         unique case (ctl.op)
            raib_pkg::OP_DIV: begin
               busy_in = 1'b1;
               cnt_in  = 7'd0;
               quo_in  = a;
               rem_in  = '0;
               dsr_in  = b;
            end
            default: begin
               res_in  = 64'(a[31:0]) * 64'(b);
               done_in = 1'b1;
            end
         endcase
      end else if (busy_ff) begin
         if (!diff[33]) begin
            rem_in = diff[32:0];
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd63) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            res_in  = quo_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      res_ff <= res_in;
   end

   assign done   = done_ff;
   assign result = res_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !ctl.start) else $error("unit started while dividing");
   a_done_one: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff || $past(ctl.start)) else $error("done held");

endmodule

@@ tb/sv/ransac_adaptive_iteration_bound_test.sv @@
// self-checking testbench for the adaptive ransac iteration bound block
`timescale 1ns / 1ps

module ransac_adaptive_iteration_bound_test;

   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
   localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;
   localparam int CYCLE_LIMIT = 4000000;
   localparam int MAX_SAMPLE_TB = 16;

   typedef struct {
      logic [2:0]  command;
      logic [19:0] inliers;
      logic [23:0] iteration;
   } request_type;

   typedef struct {
      logic        stop;
      logic [23:0] bound;
   } answer_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [2:0]  req_command;
   logic [19:0] req_inlier_count;
   logic [23:0] req_iteration_number;
   logic        rsp_valid;
   logic        rsp_stall;
   logic        rsp_stop_now;
   logic [23:0] rsp_bound_now;
   logic        csr_write;
   logic [2:0]  csr_index;
   logic [31:0] csr_data;

   request_type pending_requests[$];
   answer_type  expected_answers[$];
   int          error_count = 0;
   int          cycle_count = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          stall_mode = 0;

   // predictor copy of registers and state
   logic [31:0] log_conf;
   logic [19:0] points;
   logic [4:0]  sample_exp;
   logic [23:0] iter_limit;
   logic        time_enable;
   logic [30:0] time_limit;
   logic [23:0] bound_state;
   logic [31:0] elapsed;

   ransac_adaptive_iteration_bound dut (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // |ln(q / 2^32)| in Q8.24 via log2 and scaling by ln2
   function automatic logic [63:0] ln_magnitude(logic [63:0] q);
      int e;
      logic [63:0] x, frac, mag2;
      e = 31;
      while (e > 0 && q[e] == 1'b0) e--;
      x = q << (31 - e);
      frac = 0;
      for (int i = 0; i < 24; i++) begin
         x = (x * x) >> 31;
         frac = frac << 1;
         if (x >= ONE_Q32) begin
            frac = frac | 64'd1;
            x = x >> 1;
         end
      end
      mag2 = (64'(32 - e) << 24) - frac;
      return (mag2 * {32'd0, raib_pkg::LN2_Q32} + 64'h8000_0000) >> 32;
   endfunction

   function automatic void update_bound(logic [19:0] inliers);
      logic [63:0] num, w, p, q, k, n;
      if (points == 0) return;
      n = (sample_exp > MAX_SAMPLE_TB) ? MAX_SAMPLE_TB : sample_exp;
      num = log_conf[31] ? ONE_Q32 - {32'd0, log_conf} : 0;
      w = (inliers >= points) ? ONE_Q32 : ({44'd0, inliers} << 32) / points;
      p = ONE_Q32;
      for (int i = 0; i < n; i++) begin
         if (w == ONE_Q32) break;
         p = (p * w) >> 32;
      end
      q = ONE_Q32 - p;
      if (q == ONE_Q32) return;
      k = (q == 0) ? 0 : num / ln_magnitude(q);
      if (k < iter_limit) bound_state = k[23:0];
   endfunction

   function automatic answer_type predict_answer(request_type r);
      answer_type a;
      a.stop = 1'b0;
      case (r.command)
         raib_pkg::CMD_UPDATE: update_bound(r.inliers);
         raib_pkg::CMD_CHECK: begin
            if (r.iteration >= bound_state) a.stop = 1'b1;
            else if (time_enable && elapsed > {1'b0, time_limit}) a.stop = 1'b1;
         end
         raib_pkg::CMD_TICK: if (elapsed != 32'hFFFF_FFFF) elapsed = elapsed + 1;
         raib_pkg::CMD_RESET: bound_state = iter_limit;
         raib_pkg::CMD_START: elapsed = 0;
         default: ;
      endcase
      a.bound = bound_state;
      return a;
   endfunction

   // driver: bursts with random gaps, predicts each accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         request_type r;
         if (req_valid) begin
            r.command = req_command;
            r.inliers = req_inlier_count;
            r.iteration = req_iteration_number;
            expected_answers.push_back(predict_answer(r));
         end
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_requests.size() > 0) begin
            r = pending_requests.pop_front();
            req_command <= r.command;
            req_inlier_count <= r.inliers;
            req_iteration_number <= r.iteration;
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 40);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side: stall pattern switches among four random modes
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 300 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 1) == 0);
         default: rsp_stall <= ($urandom_range(0, 15) != 0);
      endcase
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_answers.size() == 0) begin
            $display("%0t: unexpected response stop=%0b bound=%0d",
                     $time, rsp_stop_now, rsp_bound_now);
            error_count++;
         end else begin
            answer_type a;
            a = expected_answers.pop_front();
            if (rsp_stop_now !== a.stop) begin
               $display("%0t: stop_now expected %0b actual %0b", $time, a.stop, rsp_stop_now);
               error_count++;
            end
            if (rsp_bound_now !== a.bound) begin
               $display("%0t: bound_now expected %0d actual %0d", $time, a.bound, rsp_bound_now);
               error_count++;
            end
         end
      end
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic write_reg(raib_pkg::reg_index_type idx, logic [31:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         raib_pkg::REG_LOG_CONF:   log_conf = value;
         raib_pkg::REG_POINTS:     points = value[19:0];
         raib_pkg::REG_SAMPLE:     sample_exp = value[4:0];
         raib_pkg::REG_ITER_LIMIT: iter_limit = value[23:0];
         raib_pkg::REG_TIME_EN:    time_enable = value[0];
         raib_pkg::REG_TIME_LIMIT: time_limit = value[30:0];
         default: ;
      endcase
   endtask

   task automatic add_request(logic [2:0] cmd, logic [19:0] inl, logic [23:0] iter);
      request_type r;
      r.command = cmd;
      r.inliers = inl;
      r.iteration = iter;
      pending_requests.push_back(r);
   endtask

   task automatic drain;
      do @(negedge clock);
      while (pending_requests.size() > 0 || req_valid || expected_answers.size() > 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic random_config;
      case ($urandom_range(0, 5))
         0: write_reg(raib_pkg::REG_LOG_CONF, 32'h8000_0000);
         1: write_reg(raib_pkg::REG_LOG_CONF, 32'd0);
         2: write_reg(raib_pkg::REG_LOG_CONF, $urandom_range(1, 1000));
         3: write_reg(raib_pkg::REG_LOG_CONF, raib_pkg::RST_LOG_CONF);
         default: write_reg(raib_pkg::REG_LOG_CONF,
                            32'hFFFF_FFFF - $urandom_range(0, 32'h0FFF_FFFF));
      endcase
      case ($urandom_range(0, 7))
         0: write_reg(raib_pkg::REG_POINTS, 32'hFFFFF);
         1: write_reg(raib_pkg::REG_POINTS, 32'd1);
         2: write_reg(raib_pkg::REG_POINTS, $urandom);
         default: write_reg(raib_pkg::REG_POINTS, $urandom_range(2, 2000));
      endcase
      write_reg(raib_pkg::REG_SAMPLE, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                                  : $urandom_range(1, 8));
      case ($urandom_range(0, 4))
         0: write_reg(raib_pkg::REG_ITER_LIMIT, 32'hFFFFFF);
         1: write_reg(raib_pkg::REG_ITER_LIMIT, 32'd0);
         2: write_reg(raib_pkg::REG_ITER_LIMIT, $urandom);
         default: write_reg(raib_pkg::REG_ITER_LIMIT, $urandom_range(1, 20000));
      endcase
      write_reg(raib_pkg::REG_TIME_EN, $urandom);
      write_reg(raib_pkg::REG_TIME_LIMIT,
                ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 60));
   endtask

   task automatic random_request;
      logic [2:0]  cmd;
      logic [19:0] inl;
      logic [23:0] iter;
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30) cmd = raib_pkg::CMD_UPDATE;
      else if (pick < 60) cmd = raib_pkg::CMD_CHECK;
      else if (pick < 80) cmd = raib_pkg::CMD_TICK;
      else if (pick < 88) cmd = raib_pkg::CMD_RESET;
      else if (pick < 93) cmd = raib_pkg::CMD_START;
      else cmd = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      // mostly ratios inside the point count, sometimes anything
      if ($urandom_range(0, 4) == 0) inl = 20'($urandom);
      else inl = 20'($urandom_range(0, points + 2));
      if ($urandom_range(0, 3) == 0) iter = 24'($urandom);
      else iter = 24'(bound_state + $urandom_range(0, 8) - 4);
      add_request(cmd, inl, iter);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_command = raib_pkg::CMD_UPDATE;
      req_inlier_count = 0;
      req_iteration_number = 0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = raib_pkg::REG_LOG_CONF;
      csr_data = 0;
      log_conf = raib_pkg::RST_LOG_CONF;
      points = raib_pkg::RST_POINTS;
      sample_exp = raib_pkg::RST_SAMPLE;
      iter_limit = raib_pkg::RST_ITER_LIMIT;
      time_enable = 1'b0;
      time_limit = raib_pkg::RST_TIME_LIMIT;
      bound_state = raib_pkg::RST_ITER_LIMIT;
      elapsed = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: zero ratio, full ratio, excess inliers, extremes, all commands
      add_request(raib_pkg::CMD_CHECK, 20'hFFFFF, 24'd0);
      add_request(raib_pkg::CMD_UPDATE, 20'd0, 24'hFFFFFF);
      add_request(raib_pkg::CMD_UPDATE, 20'd500, 24'd0);
      add_request(raib_pkg::CMD_CHECK, 20'd0, 24'hFFFFFF);
      add_request(raib_pkg::CMD_UPDATE, 20'd1000, 24'd0);
      add_request(raib_pkg::CMD_UPDATE, 20'hFFFFF, 24'd0);
      add_request(raib_pkg::CMD_RESET, 20'd0, 24'd0);
      add_request(raib_pkg::CMD_UPDATE, 20'd1, 24'd0);
      add_request(raib_pkg::CMD_TICK, 20'd0, 24'd0);
      add_request(raib_pkg::CMD_START, 20'd0, 24'd0);
      for (int c = CMD_SPARE_FIRST; c <= CMD_SPARE_LAST; c++)
         add_request(3'(c), 20'hFFFFF, 24'hFFFFFF);
      drain();

      // positive log confidence, zero points, zero and oversized sample, time limit
      write_reg(raib_pkg::REG_LOG_CONF, 32'd100);
      write_reg(raib_pkg::REG_TIME_EN, 32'd1);
      write_reg(raib_pkg::REG_TIME_LIMIT, 32'd0);
      add_request(raib_pkg::CMD_UPDATE, 20'd300, 24'd0);
      add_request(raib_pkg::CMD_RESET, 20'd0, 24'd0);
      add_request(raib_pkg::CMD_CHECK, 20'd0, 24'd0);
      add_request(raib_pkg::CMD_TICK, 20'd0, 24'd0);
      add_request(raib_pkg::CMD_CHECK, 20'd0, 24'd0);
      drain();
      write_reg(raib_pkg::REG_LOG_CONF, 32'h8000_0000);
      write_reg(raib_pkg::REG_POINTS, 32'd0);
      write_reg(raib_pkg::REG_ITER_LIMIT, 32'hFFFFFF);
      add_request(raib_pkg::CMD_RESET, 20'd0, 24'd0);
      add_request(raib_pkg::CMD_UPDATE, 20'd5, 24'd0);
      drain();
      write_reg(raib_pkg::REG_POINTS, 32'hFFFFF);
      write_reg(raib_pkg::REG_SAMPLE, 32'd31);
      add_request(raib_pkg::CMD_UPDATE, 20'hFFFF0, 24'd0);
      drain();
      write_reg(raib_pkg::REG_SAMPLE, 32'd0);
      add_request(raib_pkg::CMD_UPDATE, 20'd7, 24'd0);
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         random_config();
         for (int i = 0; i < 305; i++) random_request();
         drain();
      end

      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
